// File: rtl/core/e2q_pkg.sv
// Package with the types and constants of the Euler angle to quaternion unit.
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int FRAC_BITS     = 30;
    localparam int XY_W          = 33;
    localparam int Z_W           = 34;
    localparam int VAL_W         = 32;

    localparam logic signed [VAL_W-1:0] GAIN_INV  = 32'sd652032875;
    localparam logic signed [VAL_W-1:0] ONE_FIXED = 32'sd1073741824;

    localparam logic [31:0] ATAN_UNITS [0:ATAN_ENTRIES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } t_angles;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_quat;

endpackage
`default_nettype wire

// File: rtl/core/euler_to_quaternion_unit.sv
// Euler roll, pitch and yaw angles to attitude quaternion, fully pipelined.
// One angle triple may enter every clock cycle while the output is not stalled, and
// one quaternion leaves per triple, after passing through these registers in order:
// an input register, one register per CORDIC rotation stage for the three
// half angles side by side, a clamp stage, two multiply stages and the output
// register. The whole pipeline advances when the output register is empty or
// taken, so a stall at the output holds every stage in place.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire e2q_pkg::t_angles i_angles,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output e2q_pkg::t_quat        o_quat
);

    localparam int N = e2q_pkg::CORDIC_STAGES;
    localparam int XW = e2q_pkg::XY_W;
    localparam int ZW = e2q_pkg::Z_W;
    localparam int VW = e2q_pkg::VAL_W;

    function automatic logic signed [VW-1:0] mul_round(
        input logic signed [VW-1:0] a, input logic signed [VW-1:0] b);
        logic signed [2*VW-1:0] p;
        p = (a * b) + (64'sd1 <<< (e2q_pkg::FRAC_BITS - 1));
        p = p >>> e2q_pkg::FRAC_BITS;
        return p[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] clamp_one(input logic signed [XW-1:0] v);
        if (v > XW'(e2q_pkg::ONE_FIXED)) begin
            return e2q_pkg::ONE_FIXED;
        end else if (v < -XW'(e2q_pkg::ONE_FIXED)) begin
            return -e2q_pkg::ONE_FIXED;
        end
        return v[VW-1:0];
    endfunction

    function automatic logic signed [15:0] to_q15(input logic signed [VW:0] v);
        logic signed [VW:0] r;
        r = (v + (33'sd1 <<< 14)) >>> 15;
        if (r > 33'sd32767) begin
            return 16'sh7FFF;
        end else if (r < -33'sd32768) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // CORDIC lanes: index 0 roll, 1 pitch, 2 yaw.
    logic signed [XW-1:0] r_x [0:N][0:2];
    logic signed [XW-1:0] r_y [0:N][0:2];
    logic signed [ZW-1:0] r_z [0:N][0:2];
    logic [N:0]           r_vld;

    logic signed [15:0] in_ang [0:2];
    assign in_ang[0] = i_angles.roll_angle;
    assign in_ang[1] = i_angles.pitch_angle;
    assign in_ang[2] = i_angles.yaw_angle;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_x[0][l] <= XW'(e2q_pkg::GAIN_INV);
                r_y[0][l] <= '0;
                r_z[0][l] <= {{(ZW-31){in_ang[l][15]}}, in_ang[l], 15'b0};
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic signed [XW-1:0] dx, dy;
            logic signed [ZW-1:0] da;
            assign dx = r_y[i][l] >>> i;
            assign dy = r_x[i][l] >>> i;
            if (i < e2q_pkg::ATAN_ENTRIES) begin : g_rot
                assign da = ZW'(e2q_pkg::ATAN_UNITS[i]);
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        if (!r_z[i][l][ZW-1]) begin
                            r_x[i+1][l] <= r_x[i][l] - dx;
                            r_y[i+1][l] <= r_y[i][l] + dy;
                            r_z[i+1][l] <= r_z[i][l] - da;
                        end else begin
                            r_x[i+1][l] <= r_x[i][l] + dx;
                            r_y[i+1][l] <= r_y[i][l] - dy;
                            r_z[i+1][l] <= r_z[i][l] + da;
                        end
                    end
                end
            end else begin : g_hold
                assign da = '0;
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_x[i+1][l] <= r_x[i][l] + (dx & '0);
                        r_y[i+1][l] <= r_y[i][l] + (dy & '0);
                        r_z[i+1][l] <= r_z[i][l] + da;
                    end
                end
            end
        end
    end

    // Clamped sine and cosine, then pair products, then triple products.
    logic signed [VW-1:0] r_sin [0:2];
    logic signed [VW-1:0] r_cos [0:2];
    logic signed [VW-1:0] r_pair [0:3];
    logic signed [VW-1:0] r_c_y, r_s_y;
    logic signed [VW-1:0] r_trip [0:7];
    logic [2:0]           r_tail_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_cos[l] <= clamp_one(r_x[N][l]);
                r_sin[l] <= clamp_one(r_y[N][l]);
            end
            r_pair[0] <= mul_round(r_sin[0], r_cos[1]);
            r_pair[1] <= mul_round(r_cos[0], r_sin[1]);
            r_pair[2] <= mul_round(r_cos[0], r_cos[1]);
            r_pair[3] <= mul_round(r_sin[0], r_sin[1]);
            r_c_y     <= r_cos[2];
            r_s_y     <= r_sin[2];
            for (int k = 0; k < 4; k++) begin
                r_trip[2*k]   <= mul_round(r_pair[k], r_c_y);
                r_trip[2*k+1] <= mul_round(r_pair[k], r_s_y);
            end
            o_quat.quat_x <= to_q15((VW+1)'(r_trip[0]) - (VW+1)'(r_trip[3]));
            o_quat.quat_y <= to_q15((VW+1)'(r_trip[2]) + (VW+1)'(r_trip[1]));
            o_quat.quat_z <= to_q15((VW+1)'(r_trip[5]) - (VW+1)'(r_trip[6]));
            o_quat.quat_w <= to_q15((VW+1)'(r_trip[4]) + (VW+1)'(r_trip[7]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_tail_vld <= '0;
            o_valid    <= 1'b0;
        end else if (en) begin
            r_vld      <= {r_vld[N-1:0], i_valid};
            r_tail_vld <= {r_tail_vld[1:0], r_vld[N]};
            o_valid    <= r_tail_vld[2];
        end
    end

`ifndef NO_ASSERTIONS
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while output stalled");
    a_empty_stays_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == '0 && r_tail_vld == '0 && !i_valid) |=> (r_tail_vld == '0))
        else $error("transaction appeared in an empty pipeline");
`endif

endmodule
`default_nettype wire

// File: tb/euler_to_quaternion_unit_test.sv
// Self-checking testbench for the Euler angle to quaternion unit.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion_unit_test;

    localparam int LATENCY   = e2q_pkg::CORDIC_STAGES + 5;
    localparam int N_RANDOM  = 750;
    localparam longint LIMIT = 400000;

    // Attitude predictor and queue of expected quaternions.
    class quat_scoreboard;
        e2q_pkg::t_quat pending_quats[$];
        int             n_mismatch;

        function automatic longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        function automatic longint clamp_unit(longint v);
            if (v > longint'(e2q_pkg::ONE_FIXED)) return longint'(e2q_pkg::ONE_FIXED);
            if (v < -longint'(e2q_pkg::ONE_FIXED)) return -longint'(e2q_pkg::ONE_FIXED);
            return v;
        endfunction

        // Sine and cosine of half the binary angle, 30 fraction bits.
        function automatic void half_angle_sincos(logic signed [15:0] ang,
                                                  output longint s,
                                                  output longint c);
            longint x, y, z, dx, dy;
            x = longint'(e2q_pkg::GAIN_INV);
            y = 0;
            z = longint'(ang) * 32768;
            for (int i = 0; i < e2q_pkg::CORDIC_STAGES && i < e2q_pkg::ATAN_ENTRIES;
                 i++) begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(e2q_pkg::ATAN_UNITS[i]);
                end else begin
                    x += dx; y -= dy; z += longint'(e2q_pkg::ATAN_UNITS[i]);
                end
            end
            c = clamp_unit(x);
            s = clamp_unit(y);
        endfunction

        function automatic longint fix_mul(longint a, longint b);
            return floor_shift(a * b + (longint'(1) << (e2q_pkg::FRAC_BITS - 1)),
                               e2q_pkg::FRAC_BITS);
        endfunction

        function automatic longint prod3(longint a, longint b, longint c);
            return fix_mul(fix_mul(a, b), c);
        endfunction

        function automatic logic signed [15:0] round_q15(longint v);
            longint r;
            r = floor_shift(v + (longint'(1) << (e2q_pkg::FRAC_BITS - 16)),
                            e2q_pkg::FRAC_BITS - 15);
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[15:0];
        endfunction

        function automatic void note_angles(e2q_pkg::t_angles a);
            longint sr, cr, sp, cp, sy, cy;
            e2q_pkg::t_quat q;
            half_angle_sincos(a.roll_angle, sr, cr);
            half_angle_sincos(a.pitch_angle, sp, cp);
            half_angle_sincos(a.yaw_angle, sy, cy);
            q.quat_x = round_q15(prod3(sr, cp, cy) - prod3(cr, sp, sy));
            q.quat_y = round_q15(prod3(cr, sp, cy) + prod3(sr, cp, sy));
            q.quat_z = round_q15(prod3(cr, cp, sy) - prod3(sr, sp, cy));
            q.quat_w = round_q15(prod3(cr, cp, cy) + prod3(sr, sp, sy));
            pending_quats.insert(pending_quats.size(), q);
        endfunction

        function automatic void check_quat(e2q_pkg::t_quat got);
            e2q_pkg::t_quat exp_q;
            if (pending_quats.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected quaternion %h", got);
                return;
            end
            exp_q = pending_quats.pop_front();
            if (got !== exp_q) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display({"quat mismatch: exp x=%0d y=%0d z=%0d w=%0d",
                              " got x=%0d y=%0d z=%0d w=%0d"},
                             exp_q.quat_x, exp_q.quat_y, exp_q.quat_z, exp_q.quat_w,
                             got.quat_x, got.quat_y, got.quat_z, got.quat_w);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    e2q_pkg::t_angles i_angles;
    logic             o_valid;
    logic             i_ready;
    e2q_pkg::t_quat   o_quat;

    quat_scoreboard quat_sb;
    longint         cycle_count = 0;
    bit             stim_done = 1'b0;
    int             hold_off_cycles = 0;

    euler_to_quaternion_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_angles (i_angles),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_quat   (o_quat)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        quat_sb = new();
    end

    // Most gaps are short, a few are long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_angle();
        logic [15:0] a;
        int r;
        r = $urandom_range(0, 9);
        a = 16'($urandom());
        if (r == 0) begin
            case ($urandom_range(0, 5))
                0: a = 16'h8000;
                1: a = 16'h7FFF;
                2: a = 16'h0000;
                3: a = 16'h4000;
                4: a = 16'hC000;
                default: a = 16'hFFFF;
            endcase
        end
        return a;
    endfunction

    // Offer one angle triple and wait until it is accepted.
    task automatic send_angles(logic [15:0] roll, logic [15:0] pitch, logic [15:0] yaw);
        e2q_pkg::t_angles a;
        a.roll_angle = roll;
        a.pitch_angle = pitch;
        a.yaw_angle = yaw;
        i_valid <= 1'b1;
        i_angles <= a;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        quat_sb.note_angles(a);
    endtask

    task automatic idle_sender(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [15:0] corners [6];
        int gap;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_angles = '0;
        corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'h0001};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Let the output side stall for a long stretch while input keeps coming.
        hold_off_cycles = 150;
        // Directed: each angle alone at corner values, then all three together.
        for (int k = 0; k < 6; k++) begin
            send_angles(corners[k], 16'h0000, 16'h0000);
            send_angles(16'h0000, corners[k], 16'h0000);
            send_angles(16'h0000, 16'h0000, corners[k]);
        end
        send_angles(16'h8000, 16'h8000, 16'h8000);
        send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_angles(16'h4000, 16'hC000, 16'h4000);
        send_angles(16'hFFFF, 16'hAAAA, 16'h5555);
        for (int n = 0; n < N_RANDOM; n++) begin
            send_angles(pick_angle(), pick_angle(), pick_angle());
            if (n > 60) begin
                gap = pick_gap();
                idle_sender(gap);
            end
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: a long hold-off once, then random stalls with calm stretches.
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        while (hold_off_cycles == 0) @(posedge i_clk);
        i_ready <= 1'b1;
        repeat (20) @(posedge i_clk);
        i_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge i_clk);
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            quat_sb.check_quat(o_quat);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        while (quat_sb.pending_quats.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (quat_sb.n_mismatch == 0 && quat_sb.pending_quats.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
